// ----- rtl/core/lpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types, register indexes and a helper of the length prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned MAXSZ_W   = 17;
   localparam int unsigned REM_W     = 17;
   localparam int unsigned LEN_W     = 32;
   localparam int unsigned TOTAL_W   = 33;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 17;
   localparam int unsigned WIN_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LITTLE_END  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_INCL    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME   = 2'd3;

   localparam logic [1:0] PSZ_ONE = 2'd0;
   localparam logic [1:0] PSZ_TWO = 2'd1;

   localparam logic [1:0]         RST_PREFIX_SIZE = PSZ_TWO;
   localparam logic               RST_LITTLE_END  = 1'b1;
   localparam logic               RST_LEN_INCL    = 1'b0;
   localparam logic [MAXSZ_W-1:0] RST_MAX_FRAME   = 17'd65536;

   typedef struct packed {
      logic [1:0]         prefix_size_code;
      logic               little_endian;
      logic               length_includes_prefix;
      logic [MAXSZ_W-1:0] max_frame_size;
   } cfg_type;

   typedef struct packed {
      logic [2:0] header_count;
      logic       in_body;
   } status_type;

   function automatic logic [2:0] lpd_prefix_bytes(input logic [1:0] code);
      logic [2:0] n;
      case (code)
         PSZ_ONE: n = 3'd1;
         PSZ_TWO: n = 3'd2;
         default: n = 3'd4;
      endcase
      return n;
   endfunction

endpackage

// ----- rtl/core/lpd_in_reg.sv -----
// ----------------------------------------------------------------------------
// lpd_in_reg
// Input register: holds one accepted stream byte until the framer takes it.
// ----------------------------------------------------------------------------
module lpd_in_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [lpd_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       take,
   output logic                       hold_valid,
   output logic [lpd_pkg::BYTE_W-1:0] hold_byte
);
   import lpd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;

   assign req_ready  = !valid_ff || take;
   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_ready) begin
         valid_in = req_valid;
         if (req_valid) begin
            byte_in = req_data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

endmodule

// ----- rtl/core/lpd_frame_ctl.sv -----
// ----------------------------------------------------------------------------
// lpd_frame_ctl
// Framing state, header decode and the result register.
// ----------------------------------------------------------------------------
module lpd_frame_ctl #(
   parameter int unsigned MAX_FRAME_LIMIT = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lpd_pkg::cfg_type           cfg,
   input  logic                       restart,
   input  logic                       hold_valid,
   input  logic [lpd_pkg::BYTE_W-1:0] hold_byte,
   output logic                       take,
   output lpd_pkg::status_type        status,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [lpd_pkg::BYTE_W-1:0] rsp_body_byte,
   output logic                       rsp_last_of_frame,
   output logic                       rsp_empty_frame
);
   import lpd_pkg::*;

   localparam int unsigned LIM_W = $clog2(MAX_FRAME_LIMIT + 1);
   localparam int unsigned CMP_W = (LIM_W > MAXSZ_W) ? LIM_W : MAXSZ_W;
   localparam logic [CMP_W-1:0] LIMIT_C = CMP_W'(MAX_FRAME_LIMIT);

   logic [BYTE_W-1:0] win_ff [WIN_DEPTH];
   logic [BYTE_W-1:0] win_in [WIN_DEPTH];
   logic [BYTE_W-1:0] wr     [WIN_DEPTH];
   logic [2:0]        count_ff, count_in;
   logic              body_ff, body_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              ov_ff, ov_in;
   logic [BYTE_W-1:0] ob_ff, ob_in;
   logic              ol_ff, ol_in;
   logic              oe_ff, oe_in;

   logic [2:0]         p;
   logic [2:0]         cnt_inc;
   logic [LEN_W-1:0]   len;
   logic [TOTAL_W-1:0] total;
   logic [TOTAL_W-1:0] p_ext;
   logic [TOTAL_W-1:0] body_size;
   logic [CMP_W-1:0]   max_wide;
   logic [CMP_W-1:0]   eff_lim;
   logic               bad;

   assign take              = hold_valid && (!ov_ff || rsp_ready);
   assign status            = '{header_count: count_ff, in_body: body_ff};
   assign rsp_valid         = ov_ff;
   assign rsp_body_byte     = ob_ff;
   assign rsp_last_of_frame = ol_ff;
   assign rsp_empty_frame   = oe_ff;

   always_comb begin
      p        = lpd_prefix_bytes(cfg.prefix_size_code);
      p_ext    = TOTAL_W'(p);
      cnt_inc  = count_ff + 3'd1;
      wr       = win_ff;
      if (count_ff < 3'd4) begin
         wr[count_ff[1:0]] = hold_byte;
      end
      case (p)
         3'd1:    len = LEN_W'(wr[0]);
         3'd2:    len = cfg.little_endian ? LEN_W'({wr[1], wr[0]})
                                          : LEN_W'({wr[0], wr[1]});
         default: len = cfg.little_endian ? {wr[3], wr[2], wr[1], wr[0]}
                                          : {wr[0], wr[1], wr[2], wr[3]};
      endcase
      total    = cfg.length_includes_prefix ? TOTAL_W'(len) : TOTAL_W'(len) + p_ext;
      body_size = total - p_ext;
      max_wide = CMP_W'(cfg.max_frame_size);
      eff_lim  = (max_wide > LIMIT_C) ? LIMIT_C : max_wide;
      bad      = (cfg.length_includes_prefix && (TOTAL_W'(len) < p_ext))
                 || (total > TOTAL_W'(eff_lim));
   end

   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      body_in  = body_ff;
      rem_in   = rem_ff;
      ov_in    = ov_ff;
      ob_in    = ob_ff;
      ol_in    = ol_ff;
      oe_in    = oe_ff;
      if (rsp_ready) begin
         ov_in = 1'b0;
      end
      if (take) begin
         if (body_ff) begin
            rem_in = rem_ff - REM_W'(1);
            ov_in  = 1'b1;
            ob_in  = hold_byte;
            ol_in  = (rem_ff == REM_W'(1));
            oe_in  = 1'b0;
            if (rem_ff == REM_W'(1)) begin
               body_in  = 1'b0;
               count_in = 3'd0;
            end
         end else begin
            win_in   = wr;
            count_in = cnt_inc;
            if (cnt_inc >= p) begin
               if (bad) begin
                  win_in[0] = wr[1];
                  win_in[1] = wr[2];
                  win_in[2] = wr[3];
                  win_in[3] = '0;
                  count_in  = p - 3'd1;
               end else begin
                  count_in = 3'd0;
                  if (body_size == '0) begin
                     ov_in = 1'b1;
                     ob_in = '0;
                     ol_in = 1'b1;
                     oe_in = 1'b1;
                  end else begin
                     body_in = 1'b1;
                     rem_in  = body_size[REM_W-1:0];
                  end
               end
            end
         end
      end
      if (restart) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_in[i] = '0;
         end
         count_in = 3'd0;
         body_in  = 1'b0;
         rem_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
         count_ff <= 3'd0;
         body_ff  <= 1'b0;
         rem_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         win_ff   <= win_in;
         count_ff <= count_in;
         body_ff  <= body_in;
         rem_ff   <= rem_in;
         ov_ff    <= ov_in;
      end
      ob_ff <= ob_in;
      ol_ff <= ol_in;
      oe_ff <= oe_in;
   end

endmodule

// ----- rtl/core/length_prefix_deframer_core.sv -----
// ----------------------------------------------------------------------------
// length_prefix_deframer_core
// Path: an accepted byte waits in the input register until the framer takes it; results sit in the result register.
// Throughput: one byte per cycle while the result register is free or being read; framing state updates per byte.
// Reset: registers return to defaults, header window and body state clear.
// A register write also clears the header window and drops a body in progress.
// ----------------------------------------------------------------------------
module length_prefix_deframer_core #(
   parameter int unsigned MAX_FRAME_LIMIT = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lpd_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lpd_pkg::BYTE_W-1:0]    rsp_body_byte,
   output logic                          rsp_last_of_frame,
   output logic                          rsp_empty_frame,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lpd_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import lpd_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              csr_wr;
   logic              take;
   logic              hold_valid;
   logic [BYTE_W-1:0] hold_byte;
   status_type        status;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_PREFIX_SIZE: cfg_in.prefix_size_code       = csr_wdata[1:0];
            CSR_LITTLE_END:  cfg_in.little_endian          = csr_wdata[0];
            CSR_LEN_INCL:    cfg_in.length_includes_prefix = csr_wdata[0];
            CSR_MAX_FRAME:   cfg_in.max_frame_size         = csr_wdata[MAXSZ_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prefix_size_code       <= RST_PREFIX_SIZE;
         cfg_ff.little_endian          <= RST_LITTLE_END;
         cfg_ff.length_includes_prefix <= RST_LEN_INCL;
         cfg_ff.max_frame_size         <= RST_MAX_FRAME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpd_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .take          (take),
      .hold_valid    (hold_valid),
      .hold_byte     (hold_byte)
   );

   lpd_frame_ctl #(
      .MAX_FRAME_LIMIT (MAX_FRAME_LIMIT)
   ) u_frame_ctl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .restart           (csr_wr),
      .hold_valid        (hold_valid),
      .hold_byte         (hold_byte),
      .take              (take),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_body_byte     (rsp_body_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_empty_frame   (rsp_empty_frame)
   );

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_frame |-> rsp_last_of_frame && (rsp_body_byte == '0))
      else $error("empty frame result without last mark or with data");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> (status.header_count == 3'd0) && !status.in_body)
      else $error("register write did not restart framing");

   a_count_below_prefix: assert property (@(posedge clock) disable iff (reset)
      status.header_count < lpd_prefix_bytes(cfg_ff.prefix_size_code))
      else $error("header count reached prefix size");

   a_body_no_header: assert property (@(posedge clock) disable iff (reset)
      status.in_body |-> status.header_count == 3'd0)
      else $error("header bytes held while in body");

endmodule

// ----- dv/length_prefix_deframer_core_tb.sv -----
// ----------------------------------------------------------------------------
// length_prefix_deframer_core_tb
// Self-checking bench for the length prefix deframer. A cycle-free predictor
// tracks the header window and body counter for every accepted stream byte
// and queues the bytes the block must deliver. A monitor compares each
// delivered item field by field. Directed streams cover empty frames, the
// maximum frame size, too-short and oversize headers, the undefined size
// code, a zero maximum and a maximum above the limit. Random framed traffic
// then runs under several idle and stall mixes, including a long output stall.
// ----------------------------------------------------------------------------
module length_prefix_deframer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lpd_pkg::*;

   localparam int unsigned FRAME_LIMIT  = 65536;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [BYTE_W-1:0] body_byte;
      logic              last_of_frame;
      logic              empty_frame;
   } deframed_type;

   typedef logic [BYTE_W-1:0] byte_seq_type[$];

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_data_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [BYTE_W-1:0]    rsp_body_byte;
   logic                 rsp_last_of_frame;
   logic                 rsp_empty_frame;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   logic [1:0]         psz_code;
   logic               le_mode;
   logic               incl_mode;
   logic [MAXSZ_W-1:0] max_size;
   logic [BYTE_W-1:0]  hdr_win[WIN_DEPTH];
   int unsigned        hdr_count;
   logic               body_active;
   int unsigned        body_left;

   deframed_type due_bytes[$];
   int unsigned  bytes_sent;
   int unsigned  fail_count;
   int unsigned  send_idle_pct;
   int unsigned  recv_stall_pct;
   int unsigned  holdoff_cycles;

   length_prefix_deframer_core uut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int unsigned prefix_len();
      case (psz_code)
         PSZ_ONE: return 1;
         PSZ_TWO: return 2;
         default: return 4;
      endcase
   endfunction

   function automatic void restart_deframe();
      foreach (hdr_win[i]) hdr_win[i] = '0;
      hdr_count   = 0;
      body_active = 1'b0;
      body_left   = 0;
   endfunction

   function automatic void queue_result(input deframed_type item);
      due_bytes = {due_bytes, item};
   endfunction

   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      int unsigned       nb;
      int unsigned       pos;
      longint unsigned   len;
      longint unsigned   total;
      longint unsigned   lim;
      nb = prefix_len();
      if (body_active) begin
         if (body_left > 0) body_left--;
         queue_result(deframed_type'{b, body_left == 0, 1'b0});
         if (body_left == 0) begin
            body_active = 1'b0;
            hdr_count   = 0;
         end
         return;
      end
      if (hdr_count < WIN_DEPTH) hdr_win[hdr_count] = b;
      hdr_count++;
      if (hdr_count < nb) return;
      len = 0;
      for (int i = 0; i < nb; i++) begin
         pos = le_mode ? i : nb - 1 - i;
         len |= {56'd0, hdr_win[i]} << (8 * pos);
      end
      total = incl_mode ? len : nb + len;
      lim   = (max_size > FRAME_LIMIT) ? FRAME_LIMIT : max_size;
      if ((incl_mode && len < nb) || total > lim) begin
         hdr_win[0] = hdr_win[1];
         hdr_win[1] = hdr_win[2];
         hdr_win[2] = hdr_win[3];
         hdr_win[3] = '0;
         hdr_count  = nb - 1;
         return;
      end
      hdr_count = 0;
      if (total == nb) begin
         queue_result(deframed_type'{8'h00, 1'b1, 1'b1});
      end else begin
         body_active = 1'b1;
         body_left   = int'(total - nb);
      end
   endfunction

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_cycles > 0) begin
            holdoff_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      deframed_type got;
      deframed_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = deframed_type'{rsp_body_byte, rsp_last_of_frame, rsp_empty_frame};
         if (due_bytes.size() == 0) begin
            $display("%0t: unexpected item: body_byte %02h last %0b empty %0b",
                     $time, got.body_byte, got.last_of_frame, got.empty_frame);
            fail_count++;
         end else begin
            want = due_bytes.pop_front();
            if (got.body_byte !== want.body_byte) begin
               $display("%0t: body_byte mismatch: expected %02h actual %02h",
                        $time, want.body_byte, got.body_byte);
               fail_count++;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
               $display("%0t: last_of_frame mismatch: expected %0b actual %0b",
                        $time, want.last_of_frame, got.last_of_frame);
               fail_count++;
            end
            if (got.empty_frame !== want.empty_frame) begin
               $display("%0t: empty_frame mismatch: expected %0b actual %0b",
                        $time, want.empty_frame, got.empty_frame);
               fail_count++;
            end
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      deframe_byte(b);
      bytes_sent++;
   endtask

   task automatic send_seq(input byte_seq_type seq);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (due_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PREFIX_SIZE: psz_code  = data[1:0];
         CSR_LITTLE_END:  le_mode   = data[0];
         CSR_LEN_INCL:    incl_mode = data[0];
         CSR_MAX_FRAME:   max_size  = data;
         default:         max_size  = max_size;
      endcase
      restart_deframe();
   endtask

   task automatic send_frame();
      int unsigned nb;
      int unsigned pos;
      int unsigned r;
      int unsigned body_size;
      int unsigned field;
      nb = prefix_len();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
      r = $urandom_range(99);
      body_size = (r < 15) ? 0 : ((r < 90) ? $urandom_range(1, 8) : $urandom_range(9, 40));
      field = incl_mode ? body_size + nb : body_size;
      if ($urandom_range(99) < 5) field = $urandom;
      for (int i = 0; i < nb; i++) begin
         pos = le_mode ? i : nb - 1 - i;
         send_byte(8'(field >> (8 * pos)));
      end
      if ($urandom_range(99) < 5) body_size = $urandom_range(body_size);
      repeat (body_size) send_byte(8'($urandom));
   endtask

   task automatic random_config();
      logic [CSR_DAT_W-1:0] m;
      write_reg(CSR_PREFIX_SIZE, CSR_DAT_W'($urandom));
      write_reg(CSR_LITTLE_END, CSR_DAT_W'($urandom));
      write_reg(CSR_LEN_INCL, CSR_DAT_W'($urandom));
      case ($urandom_range(9))
         0:       m = RST_MAX_FRAME;
         1:       m = '1;
         2:       m = CSR_DAT_W'($urandom_range(0, 8));
         3:       m = CSR_DAT_W'($urandom);
         default: m = CSR_DAT_W'($urandom_range(48, 400));
      endcase
      write_reg(CSR_MAX_FRAME, m);
   endtask

   task automatic run_traffic(input int unsigned n_items, input int unsigned idle_pct,
                              input int unsigned stall_pct);
      int unsigned target;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (2) begin
         random_config();
         target = bytes_sent + n_items / 2;
         while (bytes_sent < target) send_frame();
      end
   endtask

   task automatic test_default_framing();
      send_seq({8'h00, 8'h00, 8'h01, 8'h00, 8'hFF, 8'hFE, 8'hFF, 8'hA5});
   endtask

   task automatic test_wide_prefix_resync();
      write_reg(CSR_PREFIX_SIZE, '1);
      write_reg(CSR_LITTLE_END, {{(CSR_DAT_W-1){1'b1}}, 1'b0});
      write_reg(CSR_LEN_INCL, '1);
      write_reg(CSR_MAX_FRAME, CSR_DAT_W'(8));
      send_seq({8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h04});
   endtask

   task automatic test_frame_size_bounds();
      write_reg(CSR_PREFIX_SIZE, '0);
      write_reg(CSR_LITTLE_END, CSR_DAT_W'(1));
      write_reg(CSR_LEN_INCL, '0);
      write_reg(CSR_MAX_FRAME, '0);
      send_seq({8'h00, 8'hFF});
      write_reg(CSR_MAX_FRAME, CSR_DAT_W'(1));
      send_seq({8'h00, 8'h01});
      write_reg(CSR_PREFIX_SIZE, CSR_DAT_W'(PSZ_TWO));
      write_reg(CSR_MAX_FRAME, '1);
      send_seq({8'hFF, 8'hFF, 8'h00, 8'h12, 8'h34});
   endtask

   task automatic test_random_traffic();
      run_traffic(120, 0, 0);
      run_traffic(100, 86, 0);
      run_traffic(100, 0, 86);
      run_traffic(100, 29, 29);
   endtask

   task automatic test_output_backpressure();
      int unsigned target;
      write_reg(CSR_PREFIX_SIZE, CSR_DAT_W'(PSZ_ONE));
      write_reg(CSR_LITTLE_END, CSR_DAT_W'(1));
      write_reg(CSR_LEN_INCL, '0);
      write_reg(CSR_MAX_FRAME, RST_MAX_FRAME);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      holdoff_cycles = 300;
      target = bytes_sent + 80;
      while (bytes_sent < target) send_frame();
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      psz_code       = RST_PREFIX_SIZE;
      le_mode        = RST_LITTLE_END;
      incl_mode      = RST_LEN_INCL;
      max_size       = RST_MAX_FRAME;
      restart_deframe();
      bytes_sent     = 0;
      fail_count     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      holdoff_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_default_framing();
      test_wide_prefix_resync();
      test_frame_size_bounds();
      test_random_traffic();
      test_output_backpressure();

      settle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
